/* hdl/mwt_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package mwt_pkg;

  localparam int MAX_DIM    = 8;
  localparam int ELEM_WIDTH = 16;

  localparam int DEPTH      = MAX_DIM * MAX_DIM;
  localparam int ADDR_W     = $clog2(DEPTH);
  localparam int IDX_W      = $clog2(MAX_DIM);
  localparam int DIM_W      = $clog2(MAX_DIM + 1);
  localparam int PROD_W     = 2 * ELEM_WIDTH;
  localparam int ACC_W      = 40;

  // fixed field widths of the ports
  localparam int CFG_DIM_W  = 4;
  localparam int RES_IDX_W  = 6;
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 5;

  // request function codes
  localparam logic [1:0] FUNC_LOAD_A = 2'd0;
  localparam logic [1:0] FUNC_LOAD_B = 2'd1;
  localparam logic [1:0] FUNC_RUN    = 2'd2;

  // register indexes
  localparam logic [2:0] REG_ROWS_A      = 3'd0;
  localparam logic [2:0] REG_COLS_A      = 3'd1;
  localparam logic [2:0] REG_ROWS_B      = 3'd2;
  localparam logic [2:0] REG_COLS_B      = 3'd3;
  localparam logic [2:0] REG_TRANSPOSE_A = 3'd4;
  localparam logic [2:0] REG_TRANSPOSE_B = 3'd5;

  typedef struct packed {
    logic [1:0]          func;
    logic [5:0]          element_index;
    logic signed [15:0]  element_value;
  } cmd_t;

  typedef struct packed {
    logic signed [39:0]  product_value;
    logic [5:0]          result_index;
    logic                last;
    logic                dim_error;
  } res_t;

  // operand pair read from the stores, tagged with its column
  typedef struct packed {
    logic                         valid;
    logic [IDX_W-1:0]             tag;
    logic signed [ELEM_WIDTH-1:0] a;
    logic signed [ELEM_WIDTH-1:0] b;
  } operand_t;

  // product travelling along the cell chain
  typedef struct packed {
    logic             valid;
    logic [IDX_W-1:0] tag;
    logic [ACC_W-1:0] prod;
  } beat_t;

  typedef struct packed {
    logic clr;
    logic shift;
  } cell_ctl_t;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_DIM_W-1:0] d);
    logic [DIM_W-1:0] r;
    if (d == '0) begin
      r = DIM_W'(1);
    end else if (32'(d) > MAX_DIM) begin
      r = DIM_W'(MAX_DIM);
    end else begin
      r = DIM_W'(d);
    end
    return r;
  endfunction

  function automatic logic signed [ELEM_WIDTH-1:0] elem_of(input logic signed [15:0] v);
    logic signed [ELEM_WIDTH+15:0] wide;
    wide = {{ELEM_WIDTH{v[15]}}, v};
    return wide[ELEM_WIDTH-1:0];
  endfunction

  function automatic logic [ACC_W-1:0] to_acc(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W+ACC_W-1:0] wide;
    wide = {{ACC_W{p[PROD_W-1]}}, p};
    return wide[ACC_W-1:0];
  endfunction

endpackage
`default_nettype wire

/* hdl/mwt_cell.sv */
`timescale 1ns / 1ps
`default_nettype none
module mwt_cell (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic [mwt_pkg::IDX_W-1:0] cell_id,
  input  wire mwt_pkg::cell_ctl_t        ctl,
  input  wire mwt_pkg::beat_t            beat_in,
  input  wire logic [mwt_pkg::ACC_W-1:0] acc_in,
  output mwt_pkg::beat_t                 beat_out,
  output logic [mwt_pkg::ACC_W-1:0]      acc_out
);

  mwt_pkg::beat_t              beat_q;
  logic [mwt_pkg::ACC_W-1:0]   acc;
  logic                        hit;

  assign hit = beat_in.valid && (beat_in.tag == cell_id);

  // pass the product on to the right neighbor
  always_ff @(posedge clk) begin
    if (rst) begin
      beat_q.valid <= 1'b0;
    end else begin
      beat_q.valid <= beat_in.valid;
    end
    beat_q.tag  <= beat_in.tag;
    beat_q.prod <= beat_in.prod;
  end

  // accumulate own column, shift left while draining
  always_ff @(posedge clk) begin
    if (ctl.clr) begin
      acc <= '0;
    end else if (ctl.shift) begin
      acc <= acc_in;
    end else if (hit) begin
      acc <= acc + beat_in.prod;
    end
  end

  assign beat_out = beat_q;
  assign acc_out  = acc;

endmodule
`default_nettype wire

/* hdl/mwt_array.sv */
`timescale 1ns / 1ps
`default_nettype none
module mwt_array (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire mwt_pkg::operand_t         opnd,
  input  wire mwt_pkg::cell_ctl_t        ctl,
  output logic [mwt_pkg::ACC_W-1:0]      head_acc,
  output logic                           busy
);

  logic                               prod_valid;
  logic [mwt_pkg::IDX_W-1:0]          prod_tag;
  logic signed [mwt_pkg::PROD_W-1:0]  prod_q;

  mwt_pkg::beat_t              beats [mwt_pkg::MAX_DIM+1];
  logic [mwt_pkg::ACC_W-1:0]   accs  [mwt_pkg::MAX_DIM];

  // single multiplier stage at the head of the chain
  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
    end else begin
      prod_valid <= opnd.valid;
    end
    prod_tag <= opnd.tag;
    prod_q   <= mwt_pkg::PROD_W'(opnd.a) * mwt_pkg::PROD_W'(opnd.b);
  end

  assign beats[0] = '{valid: prod_valid, tag: prod_tag, prod: mwt_pkg::to_acc(prod_q)};

  for (genvar c = 0; c < mwt_pkg::MAX_DIM; c++) begin : g_cell
    logic [mwt_pkg::ACC_W-1:0] right_acc;
    if (c == mwt_pkg::MAX_DIM - 1) begin : g_tail
      assign right_acc = '0;
    end else begin : g_mid
      assign right_acc = accs[c+1];
    end
    mwt_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .cell_id  (mwt_pkg::IDX_W'(c)),
      .ctl      (ctl),
      .beat_in  (beats[c]),
      .acc_in   (right_acc),
      .beat_out (beats[c+1]),
      .acc_out  (accs[c])
    );
  end

  assign head_acc = accs[0];

  // any product still moving through the chain
  always_comb begin
    busy = 1'b0;
    for (int c = 0; c <= mwt_pkg::MAX_DIM; c++) begin
      busy = busy | beats[c].valid;
    end
  end

endmodule
`default_nettype wire

/* hdl/matrix_multiply_with_transpose_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// matrix multiply with optional transposed operands. load requests (func 0/1) write one
// signed q8.8 element of a or b into its 64-entry store and are taken one per cycle
// while idle; a load never gives a result. a run request (func 2) computes c = a * b one
// row at a time: for row i the block reads one a/b pair per cycle (k outer, column
// inner), a single 16x16 multiplier feeds the products into a chain of MAX_DIM
// accumulator cells where cell j keeps entry c[i][j], and the chain then shifts its
// sums out of cell 0 in column order. the flush phase waits until no product is left in
// the chain. requests are not taken during a run. a mismatch of cols_a and rows_b gives
// one error result with last set. dimension registers are clamped to 1..MAX_DIM before
// use; store entries hold nothing valid until written and must be loaded before a run
// reads them. registers sit at byte address 4*index of the apb port, written at the
// access phase; pready is tied high.
module matrix_multiply_with_transpose_core (
  input  wire logic                            clk,
  input  wire logic                            rst,
  // request channel
  input  wire logic                            cmd_valid,
  output logic                                 cmd_ready,
  input  wire mwt_pkg::cmd_t                   cmd,
  // result channel
  output logic                                 res_valid,
  input  wire logic                            res_ready,
  output mwt_pkg::res_t                        res,
  // configuration port
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [mwt_pkg::APB_ADDR_W-1:0]  paddr,
  input  wire logic [mwt_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [mwt_pkg::APB_DATA_W-1:0]       prdata,
  output logic                                 pready
);

  localparam int MW = mwt_pkg::IDX_W + mwt_pkg::DIM_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FEED,
    ST_FLUSH,
    ST_DRAIN,
    ST_ERROR
  } state_t;

  state_t state;

  // configuration registers, raw as written
  logic [mwt_pkg::CFG_DIM_W-1:0] rows_a, cols_a, rows_b, cols_b;
  logic                          transpose_a, transpose_b;
  logic [2:0]                    reg_idx;
  logic                          cfg_write;

  // clamped dimensions
  logic [mwt_pkg::DIM_W-1:0] ra_c, ca_c, rb_c, cb_c;

  // walk counters: row, inner index, column, drain column
  logic [mwt_pkg::IDX_W-1:0] i, k, j, dj;

  // operand stores
  logic signed [mwt_pkg::ELEM_WIDTH-1:0] a_mem [mwt_pkg::DEPTH];
  logic signed [mwt_pkg::ELEM_WIDTH-1:0] b_mem [mwt_pkg::DEPTH];
  logic signed [mwt_pkg::ELEM_WIDTH-1:0] a_q, b_q;
  logic [mwt_pkg::ADDR_W-1:0]            wr_addr, a_addr, b_addr;
  logic [MW-1:0]                         a_full, b_full, r_full;
  logic                                  idx_ok, load_a, load_b;

  // read pipeline tag alongside the store outputs
  logic                       rd_valid;
  logic [mwt_pkg::IDX_W-1:0]  rd_tag;

  logic                       cmd_take, cmd_run, issue;
  logic                       out_free, drain_load, row_done;
  logic                       j_last, k_last, i_last;
  logic                       busy;
  logic [mwt_pkg::ACC_W-1:0]  head_acc;
  mwt_pkg::operand_t          opnd;
  mwt_pkg::cell_ctl_t         ctl;

  // ---------------------------------------------------------------- config port
  assign pready    = 1'b1;
  assign reg_idx   = paddr[4:2];
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_a      <= mwt_pkg::CFG_DIM_W'(8);
      cols_a      <= mwt_pkg::CFG_DIM_W'(8);
      rows_b      <= mwt_pkg::CFG_DIM_W'(8);
      cols_b      <= mwt_pkg::CFG_DIM_W'(8);
      transpose_a <= 1'b0;
      transpose_b <= 1'b0;
    end else if (cfg_write) begin
      unique case (reg_idx)
        mwt_pkg::REG_ROWS_A:      rows_a      <= pwdata[mwt_pkg::CFG_DIM_W-1:0];
        mwt_pkg::REG_COLS_A:      cols_a      <= pwdata[mwt_pkg::CFG_DIM_W-1:0];
        mwt_pkg::REG_ROWS_B:      rows_b      <= pwdata[mwt_pkg::CFG_DIM_W-1:0];
        mwt_pkg::REG_COLS_B:      cols_b      <= pwdata[mwt_pkg::CFG_DIM_W-1:0];
        mwt_pkg::REG_TRANSPOSE_A: transpose_a <= pwdata[0];
        mwt_pkg::REG_TRANSPOSE_B: transpose_b <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      mwt_pkg::REG_ROWS_A:      prdata = mwt_pkg::APB_DATA_W'(rows_a);
      mwt_pkg::REG_COLS_A:      prdata = mwt_pkg::APB_DATA_W'(cols_a);
      mwt_pkg::REG_ROWS_B:      prdata = mwt_pkg::APB_DATA_W'(rows_b);
      mwt_pkg::REG_COLS_B:      prdata = mwt_pkg::APB_DATA_W'(cols_b);
      mwt_pkg::REG_TRANSPOSE_A: prdata = mwt_pkg::APB_DATA_W'(transpose_a);
      mwt_pkg::REG_TRANSPOSE_B: prdata = mwt_pkg::APB_DATA_W'(transpose_b);
      default:                  prdata = '0;
    endcase
  end

  assign ra_c = mwt_pkg::clamp_dim(rows_a);
  assign ca_c = mwt_pkg::clamp_dim(cols_a);
  assign rb_c = mwt_pkg::clamp_dim(rows_b);
  assign cb_c = mwt_pkg::clamp_dim(cols_b);

  // ---------------------------------------------------------------- request side
  assign cmd_ready = (state == ST_IDLE);
  assign cmd_take  = cmd_valid && cmd_ready;
  assign cmd_run   = cmd_take && (cmd.func == mwt_pkg::FUNC_RUN);

  // loads beyond the store depth are dropped
  assign idx_ok  = (32'(cmd.element_index) < mwt_pkg::DEPTH);
  assign wr_addr = mwt_pkg::ADDR_W'(cmd.element_index);
  assign load_a  = cmd_take && idx_ok && (cmd.func == mwt_pkg::FUNC_LOAD_A);
  assign load_b  = cmd_take && idx_ok && (cmd.func == mwt_pkg::FUNC_LOAD_B);

  // ---------------------------------------------------------------- store addressing
  // transposed operands are stored column index major
  assign a_full = transpose_a ? (MW'(k) * MW'(ra_c) + MW'(i))
                              : (MW'(i) * MW'(ca_c) + MW'(k));
  assign b_full = transpose_b ? (MW'(j) * MW'(ca_c) + MW'(k))
                              : (MW'(k) * MW'(cb_c) + MW'(j));
  assign a_addr = a_full[mwt_pkg::ADDR_W-1:0];
  assign b_addr = b_full[mwt_pkg::ADDR_W-1:0];

  always_ff @(posedge clk) begin
    if (load_a) begin
      a_mem[wr_addr] <= mwt_pkg::elem_of(cmd.element_value);
    end
    a_q <= a_mem[a_addr];
  end

  always_ff @(posedge clk) begin
    if (load_b) begin
      b_mem[wr_addr] <= mwt_pkg::elem_of(cmd.element_value);
    end
    b_q <= b_mem[b_addr];
  end

  // ---------------------------------------------------------------- sequencing
  assign issue      = (state == ST_FEED);
  assign j_last     = (mwt_pkg::DIM_W'(j)  == cb_c - mwt_pkg::DIM_W'(1));
  assign k_last     = (mwt_pkg::DIM_W'(k)  == ca_c - mwt_pkg::DIM_W'(1));
  assign i_last     = (mwt_pkg::DIM_W'(i)  == ra_c - mwt_pkg::DIM_W'(1));
  assign out_free   = !res_valid || res_ready;
  assign drain_load = (state == ST_DRAIN) && out_free;
  assign row_done   = drain_load && (mwt_pkg::DIM_W'(dj) == cb_c - mwt_pkg::DIM_W'(1));
  assign r_full     = MW'(i) * MW'(cb_c) + MW'(dj);

  // accumulators clear at run start and as a row's last sum leaves
  assign ctl.clr   = cmd_run || row_done;
  assign ctl.shift = drain_load;

  assign opnd = '{valid: rd_valid, tag: rd_tag, a: a_q, b: b_q};

  mwt_array u_array (
    .clk      (clk),
    .rst      (rst),
    .opnd     (opnd),
    .ctl      (ctl),
    .head_acc (head_acc),
    .busy     (busy)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      res_valid <= 1'b0;
      rd_valid  <= 1'b0;
    end else begin
      rd_valid <= issue;
      rd_tag   <= j;
      if (res_valid && res_ready) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (cmd_run) begin
            i <= '0;
            j <= '0;
            k <= '0;
            state <= (ca_c != rb_c) ? ST_ERROR : ST_FEED;
          end
        end
        ST_ERROR: begin
          if (out_free) begin
            res_valid <= 1'b1;
            res <= '{product_value: '0, result_index: '0, last: 1'b1, dim_error: 1'b1};
            state <= ST_IDLE;
          end
        end
        ST_FEED: begin
          // one operand pair per cycle, columns inner
          if (j_last) begin
            j <= '0;
            if (k_last) begin
              state <= ST_FLUSH;
            end else begin
              k <= k + 1'b1;
            end
          end else begin
            j <= j + 1'b1;
          end
        end
        ST_FLUSH: begin
          // wait for the last product to reach its cell
          if (!rd_valid && !busy) begin
            dj    <= '0;
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (out_free) begin
            res_valid <= 1'b1;
            res <= '{product_value: $signed(head_acc),
                     result_index:  mwt_pkg::RES_IDX_W'(r_full),
                     last:          row_done && i_last,
                     dim_error:     1'b0};
            if (row_done) begin
              dj <= '0;
              if (i_last) begin
                state <= ST_IDLE;
              end else begin
                i     <= i + 1'b1;
                j     <= '0;
                k     <= '0;
                state <= ST_FEED;
              end
            end else begin
              dj <= dj + 1'b1;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

/* hdl/mwt_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
module mwt_checker (
  input wire logic           clk,
  input wire logic           rst,
  input wire logic           cmd_valid,
  input wire logic           cmd_ready,
  input wire mwt_pkg::cmd_t  cmd,
  input wire logic           res_valid,
  input wire logic           res_ready,
  input wire mwt_pkg::res_t  res
);

  // a stalled result holds
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res))
    else $error("result changed while stalled");

  // error result is a lone, empty, final result
  a_err_form: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.dim_error |->
      res.last && (res.product_value == '0) && (res.result_index == '0))
    else $error("malformed dimension error result");

  // a run request blocks further requests
  a_run_busy: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_ready && (cmd.func == mwt_pkg::FUNC_RUN) |=> !cmd_ready)
    else $error("request taken during a run");

  // no result survives reset
  a_rst_clear: assert property (@(posedge clk)
    rst |=> !res_valid)
    else $error("result valid after reset");

endmodule

bind matrix_multiply_with_transpose_core mwt_checker u_mwt_checker (.*);
`default_nettype wire
